FILE: rtl/cxyml_pkg.sv
package cxyml_pkg;

  // operand widths
  localparam int AbsW  = 17;  // |dir| and |a|+|b|, |a+-b|
  localparam int ParW  = 20;  // axis limit, feeds zero extended
  localparam int ProdW = 37;  // |a| * limit
  localparam int DsumW = 38;  // |a|*P2 + |b|*P1
  localparam int PpW   = 40;  // P1 * P2
  localparam int DenW  = 55;  // m * dsum
  localparam int NumW  = 57;  // s * P1 * P2
  localparam int CapW  = 32;
  localparam int NumLanes = 4;

  // divider: one input stage plus one stage per quotient bit
  localparam int DivLat = CapW + 1;

  localparam logic [19:0] AccelReset = 20'd1000;
  localparam logic [15:0] FeedReset  = 16'd300;

  typedef enum logic [2:0] {
    REG_ACCEL_X = 3'd0,
    REG_ACCEL_Y = 3'd1,
    REG_ACCEL_U = 3'd2,
    REG_FEED_X  = 3'd3,
    REG_FEED_Y  = 3'd4,
    REG_FEED_U  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic en;
  } div_ctl_t;

endpackage

FILE: rtl/cxyml_div.sv
module cxyml_div #(
  parameter int HW = 40,
  parameter int DW = 55
) (
  input  logic                       clk,
  input  cxyml_pkg::div_ctl_t        ctl,
  input  logic [HW-1:0]              num_hi,
  input  logic [31:0]                num_lo,
  input  logic [DW-1:0]              den,
  output logic [cxyml_pkg::CapW-1:0] quo
);

  localparam int CW = (HW > DW) ? HW : DW;
  localparam int NS = cxyml_pkg::CapW;

  logic [CW-1:0] hi_ext, den_ext;
  logic          sat_nxt;

  logic [DW-1:0] rem_r [0:NS];
  logic [DW-1:0] den_r [0:NS];
  logic [31:0]   lo_r  [0:NS];
  logic          sat_r [0:NS];
  logic [NS-1:0] q_r   [1:NS];

  assign hi_ext  = CW'(num_hi);
  assign den_ext = CW'(den);
  // quotient would not fit in 32 bits (also covers a zero divisor)
  assign sat_nxt = hi_ext >= den_ext;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= sat_nxt ? '0 : hi_ext[DW-1:0];
      den_r[0] <= den;
      lo_r[0]  <= num_lo;
      sat_r[0] <= sat_nxt;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [NS-2:0] q_prev;
    logic [DW:0]   sh;
    logic [DW+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = q_r[k][NS-2:0];
    end

    assign sh   = {rem_r[k], lo_r[k][31]};
    assign diff = {1'b0, sh} - {2'b00, den_r[k]};
    assign ge   = !diff[DW+1];

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_r[k+1] <= den_r[k];
        lo_r[k+1]  <= {lo_r[k][30:0], 1'b0};
        sat_r[k+1] <= sat_r[k];
        q_r[k+1]   <= {q_prev, ge};
      end
    end
  end

  assign quo = sat_r[NS] ? '1 : q_r[NS];

endmodule

FILE: rtl/corexyu_motion_limit.sv
// CoreXYU belt-pair speed and acceleration limiter.
// Input stream (in_*): one item per move, a normalized direction X, Y, U in
// signed fixed point with DIR_FRAC_BITS fraction bits. Each item gives exactly
// one result item on the output stream (out_*): for the XY and UY belt pairs
// a valid flag plus speed and acceleration caps, floored and saturated to
// 32 bits. A pair whose hardest motor factor max(|a+b|,|a-b|) is not above
// 0.01 reports valid 0 and zero caps.
// Config port (cfg_*): APB style, six limit registers at byte address 4*i,
// write only while the stream is idle. pready is always high.
// Depth: 37 register stages lie between an accepted input item and its result.
// Stages: four arithmetic stages (abs/max, products, sum, products) then a
// 33-stage restoring divider (one input stage, then one quotient bit per
// stage), four dividers in parallel.
// Throughput: one item per cycle. The whole pipe advances together; when the
// last stage holds a result that the receiver does not take, every stage
// holds and in_tready drops, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipe and loads the default
// limits (accel 1000, feed 300).
module corexyu_motion_limit #(
  parameter int DIR_FRAC_BITS = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // dir_x[15:0], dir_y[31:16], dir_u[47:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  // xy_valid[0], xy_speed_cap[32:1], xy_accel_cap[64:33], uy_valid[65],
  // uy_speed_cap[97:66], uy_accel_cap[129:98], zero fill
  output logic [135:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW  = cxyml_pkg::AbsW;
  localparam int PW  = cxyml_pkg::ParW;
  localparam int NL  = cxyml_pkg::NumLanes;
  localparam int NW  = cxyml_pkg::NumW + DIR_FRAC_BITS;
  localparam int HW  = NW - 32;
  localparam int DEPTH = 4 + cxyml_pkg::DivLat;
  localparam logic [31:0] THRESH =
    32'(((64'd1 << DIR_FRAC_BITS) + 64'd50) / 64'd100);

  // ---------------- configuration registers ----------------
  logic [19:0] accel_x_r, accel_y_r, accel_u_r;
  logic [15:0] feed_x_r, feed_y_r, feed_u_r;
  logic        cfg_wr;
  cxyml_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cxyml_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_x_r <= cxyml_pkg::AccelReset;
      accel_y_r <= cxyml_pkg::AccelReset;
      accel_u_r <= cxyml_pkg::AccelReset;
      feed_x_r  <= cxyml_pkg::FeedReset;
      feed_y_r  <= cxyml_pkg::FeedReset;
      feed_u_r  <= cxyml_pkg::FeedReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cxyml_pkg::REG_ACCEL_X: accel_x_r <= cfg_pwdata[19:0];
        cxyml_pkg::REG_ACCEL_Y: accel_y_r <= cfg_pwdata[19:0];
        cxyml_pkg::REG_ACCEL_U: accel_u_r <= cfg_pwdata[19:0];
        cxyml_pkg::REG_FEED_X:  feed_x_r  <= cfg_pwdata[15:0];
        cxyml_pkg::REG_FEED_Y:  feed_y_r  <= cfg_pwdata[15:0];
        cxyml_pkg::REG_FEED_U:  feed_u_r  <= cfg_pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cxyml_pkg::REG_ACCEL_X: cfg_prdata = {12'b0, accel_x_r};
      cxyml_pkg::REG_ACCEL_Y: cfg_prdata = {12'b0, accel_y_r};
      cxyml_pkg::REG_ACCEL_U: cfg_prdata = {12'b0, accel_u_r};
      cxyml_pkg::REG_FEED_X:  cfg_prdata = {16'b0, feed_x_r};
      cxyml_pkg::REG_FEED_Y:  cfg_prdata = {16'b0, feed_y_r};
      cxyml_pkg::REG_FEED_U:  cfg_prdata = {16'b0, feed_u_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                vld_r [1:DEPTH];
  logic [1:0]          fl_r  [1:DEPTH];   // pair valid flags {uy, xy}
  logic                en;
  cxyml_pkg::div_ctl_t div_ctl;

  assign en          = !vld_r[DEPTH] || out_tready;
  assign in_tready   = en;
  assign div_ctl.en  = en;

  // ---------------- stage 1: magnitudes, hardest factor ----------------
  logic signed [15:0] dx, dy, du;
  logic [AW-1:0] ax, ay, au;
  logic [AW-1:0] m_nxt [0:1];
  logic [AW-1:0] s_nxt [0:1];
  logic [1:0]    fl_nxt;

  assign dx = in_tdata[15:0];
  assign dy = in_tdata[31:16];
  assign du = in_tdata[47:32];

  function automatic logic [AW-1:0] mag17(input logic signed [17:0] v);
    logic signed [17:0] n;
    n = -v;
    mag17 = v[17] ? n[AW-1:0] : v[AW-1:0];
  endfunction

  assign ax = mag17(18'(dx));
  assign ay = mag17(18'(dy));
  assign au = mag17(18'(du));

  for (genvar p = 0; p < 2; p++) begin : g_pair
    logic signed [17:0] a, b;
    logic [AW-1:0] sm, df;
    assign a  = (p == 0) ? 18'(dx) : 18'(du);
    assign b  = 18'(dy);
    assign sm = mag17(a + b);
    assign df = mag17(a - b);
    assign m_nxt[p]  = (sm > df) ? sm : df;
    assign s_nxt[p]  = ((p == 0) ? ax : au) + ay;
    assign fl_nxt[p] = {15'b0, m_nxt[p]} > THRESH;
  end

  logic [AW-1:0] ax_r, ay_r, au_r;
  logic [AW-1:0] m1_r [0:1];
  logic [AW-1:0] s1_r [0:1];

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= ax;
      ay_r  <= ay;
      au_r  <= au;
      m1_r  <= m_nxt;
      s1_r  <= s_nxt;
    end
  end

  // ---------------- stages 2..4 per lane ----------------
  // lane 0: XY speed, 1: XY accel, 2: UY speed, 3: UY accel
  localparam int CW_Q = cxyml_pkg::CapW;
  logic [cxyml_pkg::DenW-1:0] den4_r [0:NL-1];
  logic [cxyml_pkg::NumW-1:0] x4_r   [0:NL-1];
  logic [CW_Q-1:0]            cap    [0:NL-1];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    localparam int P = l / 2;
    logic [PW-1:0] p1, p2;
    logic [AW-1:0] aa, ab;
    logic [cxyml_pkg::ProdW-1:0] pa2_r, pb2_r;
    logic [cxyml_pkg::PpW-1:0]   pp2_r, pp3_r;
    logic [cxyml_pkg::DsumW-1:0] ds3_r;
    logic [AW-1:0]               s2_r, m2_r, s3_r, m3_r;
    logic [NW-1:0]               num;

    always_comb begin
      case (l)
        0:       begin p1 = PW'(feed_x_r); p2 = PW'(feed_y_r); end
        1:       begin p1 = accel_x_r;     p2 = accel_y_r;     end
        2:       begin p1 = PW'(feed_u_r); p2 = PW'(feed_y_r); end
        default: begin p1 = accel_u_r;     p2 = accel_y_r;     end
      endcase
    end

    assign aa = (P == 0) ? ax_r : au_r;
    assign ab = ay_r;

    always_ff @(posedge clk) begin
      if (en) begin
        pa2_r   <= cxyml_pkg::ProdW'(aa) * cxyml_pkg::ProdW'(p2);
        pb2_r   <= cxyml_pkg::ProdW'(ab) * cxyml_pkg::ProdW'(p1);
        pp2_r   <= cxyml_pkg::PpW'(p1) * cxyml_pkg::PpW'(p2);
        s2_r    <= s1_r[P];
        m2_r    <= m1_r[P];
        ds3_r   <= cxyml_pkg::DsumW'(pa2_r) + cxyml_pkg::DsumW'(pb2_r);
        pp3_r   <= pp2_r;
        s3_r    <= s2_r;
        m3_r    <= m2_r;
        den4_r[l] <= cxyml_pkg::DenW'(m3_r) * cxyml_pkg::DenW'(ds3_r);
        x4_r[l]   <= cxyml_pkg::NumW'(s3_r) * cxyml_pkg::NumW'(pp3_r);
      end
    end

    assign num = {x4_r[l], {DIR_FRAC_BITS{1'b0}}};

    cxyml_div #(
      .HW (HW),
      .DW (cxyml_pkg::DenW)
    ) u_div (
      .clk    (clk),
      .ctl    (div_ctl),
      .num_hi (num[NW-1:32]),
      .num_lo (num[31:0]),
      .den    (den4_r[l]),
      .quo    (cap[l])
    );
  end

  // ---------------- valid and pair flag chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int i = 2; i <= DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[1] <= fl_nxt;
      for (int i = 2; i <= DEPTH; i++) fl_r[i] <= fl_r[i-1];
    end
  end

  // ---------------- result ----------------
  logic [1:0] fl_out;
  assign fl_out     = fl_r[DEPTH];
  assign out_tvalid = vld_r[DEPTH];
  assign out_tdata  = {6'b0,
                       fl_out[1] ? cap[3] : '0,
                       fl_out[1] ? cap[2] : '0,
                       fl_out[1],
                       fl_out[0] ? cap[1] : '0,
                       fl_out[0] ? cap[0] : '0,
                       fl_out[0]};

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_xy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[64:1] == '0)
    else $error("XY caps nonzero on invalid pair");

  a_uy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[65] |-> out_tdata[129:66] == '0)
    else $error("UY caps nonzero on invalid pair");

  a_cfg_feed_x: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_idx == cxyml_pkg::REG_FEED_X |=> feed_x_r == $past(cfg_pwdata[15:0]))
    else $error("feed_x write lost");

endmodule

FILE: dv/corexyu_motion_limit_tb.sv
module corexyu_motion_limit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Result of one item, one entry per belt pair.
  typedef struct {
    logic        xy_valid;
    logic [31:0] xy_speed;
    logic [31:0] xy_accel;
    logic        uy_valid;
    logic [31:0] uy_speed;
    logic [31:0] uy_accel;
  } caps_t;

  localparam int Thresh  = ((1 << 15) + 50) / 100;  // 0.01 in Q1.15
  localparam int PipeLat = 37;
  localparam int Limit   = 20000;

  // Limit register copy plus the queue of pending caps.
  class caps_scoreboard;
    logic [19:0] acc_x, acc_y, acc_u;
    logic [15:0] fd_x, fd_y, fd_u;
    caps_t       pending[$];
    int          errors;
    int          checked;
    int          pairs_valid;

    function new();
      acc_x = cxyml_pkg::AccelReset;
      acc_y = cxyml_pkg::AccelReset;
      acc_u = cxyml_pkg::AccelReset;
      fd_x = cxyml_pkg::FeedReset;
      fd_y = cxyml_pkg::FeedReset;
      fd_u = cxyml_pkg::FeedReset;
      errors = 0; checked = 0; pairs_valid = 0;
    endfunction

    function void set_reg(cxyml_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        cxyml_pkg::REG_ACCEL_X: acc_x = v[19:0];
        cxyml_pkg::REG_ACCEL_Y: acc_y = v[19:0];
        cxyml_pkg::REG_ACCEL_U: acc_u = v[19:0];
        cxyml_pkg::REG_FEED_X:  fd_x = v[15:0];
        cxyml_pkg::REG_FEED_Y:  fd_y = v[15:0];
        cxyml_pkg::REG_FEED_U:  fd_u = v[15:0];
        default: ;
      endcase
    endfunction

    // floor(s*p1*p2*2^15 / den), saturating; den 0 saturates too
    function logic [31:0] cap_of(logic [16:0] s, logic [19:0] p1, logic [19:0] p2,
                                 logic [16:0] m, logic [16:0] aa, logic [16:0] ab);
      logic [127:0] num, den, q;
      num = ({111'd0, s} * p1 * p2) << 15;
      den = {111'd0, m} * ({111'd0, aa} * p2 + {111'd0, ab} * p1);
      if (den == 0) return 32'hFFFF_FFFF;
      q = num / den;
      return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function void pair(logic signed [15:0] a, logic signed [15:0] b,
                       logic [19:0] ca, logic [19:0] cb, logic [19:0] fa,
                       logic [19:0] fb, output logic v, output logic [31:0] sp,
                       output logic [31:0] ac);
      int sa, sb, sum, dif, m;
      sa = a; sb = b;
      sum = (sa + sb < 0) ? -(sa + sb) : sa + sb;
      dif = (sa - sb < 0) ? -(sa - sb) : sa - sb;
      m = (sum > dif) ? sum : dif;
      sa = (sa < 0) ? -sa : sa;
      sb = (sb < 0) ? -sb : sb;
      v = 1'b0; sp = '0; ac = '0;
      if (m > Thresh) begin
        v = 1'b1;
        sp = cap_of(17'(sa + sb), fa, fb, 17'(m), 17'(sa), 17'(sb));
        ac = cap_of(17'(sa + sb), ca, cb, 17'(m), 17'(sa), 17'(sb));
      end
    endfunction

    function void note_move(logic [47:0] d);
      caps_t c;
      pair(d[15:0], d[31:16], acc_x, acc_y, {4'd0, fd_x}, {4'd0, fd_y},
           c.xy_valid, c.xy_speed, c.xy_accel);
      pair(d[47:32], d[31:16], acc_u, acc_y, {4'd0, fd_u}, {4'd0, fd_y},
           c.uy_valid, c.uy_speed, c.uy_accel);
      pending.push_back(c);
    endfunction

    function void check_caps(logic [135:0] t);
      caps_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", t);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      pairs_valid += e.xy_valid + e.uy_valid;
      if (t[0] !== e.xy_valid) begin
        $error("xy_valid exp %0d got %0d", e.xy_valid, t[0]); errors++;
      end
      if (t[32:1] !== e.xy_speed) begin
        $error("xy_speed_cap exp %0d got %0d", e.xy_speed, t[32:1]); errors++;
      end
      if (t[64:33] !== e.xy_accel) begin
        $error("xy_accel_cap exp %0d got %0d", e.xy_accel, t[64:33]); errors++;
      end
      if (t[65] !== e.uy_valid) begin
        $error("uy_valid exp %0d got %0d", e.uy_valid, t[65]); errors++;
      end
      if (t[97:66] !== e.uy_speed) begin
        $error("uy_speed_cap exp %0d got %0d", e.uy_speed, t[97:66]); errors++;
      end
      if (t[129:98] !== e.uy_accel) begin
        $error("uy_accel_cap exp %0d got %0d", e.uy_accel, t[129:98]); errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;    // dir_x[15:0], dir_y[31:16], dir_u[47:32]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // xy_valid[0], xy_speed[32:1], xy_accel[64:33], uy_valid[65],
  // uy_speed[97:66], uy_accel[129:98]
  logic [135:0] out_tdata;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  caps_scoreboard sb = new();
  int  idle_cycles = 0;

  always #1 clk = ~clk;

  corexyu_motion_limit dut (.*);

  // Gap length: mostly 0..2, sometimes long. Phases with mode 0 never idle.
  int gap_mode = 1;
  function automatic int pick_gap();
    if (gap_mode == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
  endfunction

  // Receiver: random stalls; results checked at the accepting edge.
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_caps(out_tdata);
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_move(logic [47:0] d);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_move(d);
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every pending cap, then let the pipe drain.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeLat + 4) @(posedge clk);
  endtask

  task automatic write_limit(cxyml_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 700)) - 16'd350;   // around threshold
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_moves(int n);
    logic [15:0] x, y, u;
    repeat (n) begin
      x = rand_dir(); y = rand_dir(); u = rand_dir();
      // Diagonal moves drive one belt of a pair near zero.
      if ($urandom_range(0, 7) == 0) x = y;
      if ($urandom_range(0, 7) == 0) u = -y;
      send_move({u, y, x});
    end
    end_stream();
  endtask

  task automatic set_limits(logic [19:0] ax, logic [19:0] ay, logic [19:0] au,
                            logic [15:0] fx, logic [15:0] fy, logic [15:0] fu);
    write_limit(cxyml_pkg::REG_ACCEL_X, {12'd0, ax});
    write_limit(cxyml_pkg::REG_ACCEL_Y, {12'd0, ay});
    write_limit(cxyml_pkg::REG_ACCEL_U, {12'd0, au});
    write_limit(cxyml_pkg::REG_FEED_X, {16'd0, fx});
    write_limit(cxyml_pkg::REG_FEED_Y, {16'd0, fy});
    write_limit(cxyml_pkg::REG_FEED_U, {16'd0, fu});
  endtask

  initial begin
    logic [47:0] directed[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, threshold edges (328 invalid, 329 valid), axis moves.
    directed = '{
      {16'd0, 16'd0, 16'd0}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
      {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h7FFF, 16'h7FFF},
      {16'd0, 16'd0, 16'd328}, {16'd329, 16'd0, 16'd329},
      {16'd0, -16'sd329, 16'd0}, {16'd164, 16'd164, 16'd164},
      {16'd165, 16'd164, -16'sd164}, {16'd0, 16'd32767, 16'd0},
      {16'd32767, 16'd0, 16'd0}, {16'hFFFF, 16'hFFFF, 16'h0001},
      {16'd23170, 16'd23170, -16'sd23170}, {16'hAAAA, 16'h5555, 16'hF0F0}
    };
    foreach (directed[i]) send_move(directed[i]);
    end_stream();
    drain();

    // Zero limits (divide by zero), then maximum limits (saturation).
    set_limits(20'd0, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0);
    foreach (directed[i]) send_move(directed[i]);
    end_stream();
    drain();
    set_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_moves(60);
    drain();

    // Mixed limits; only the UY pair gets zero limits (accel U, feed U), mixed terms.
    set_limits(20'd1, 20'hFFFFF, 20'd0, 16'hFFFF, 16'd1, 16'd0);
    random_moves(40);
    drain();

    // Random limits with idle stretches, then a back-to-back burst.
    repeat (4) begin
      set_limits(20'($urandom()), 20'($urandom()), 20'($urandom()),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      random_moves(60);
      drain();
    end
    gap_mode = 0;
    random_moves(60);
    drain();
    gap_mode = 1;

    $display("Checked %0d result items, %0d valid belt pairs, over 8 limit settings.",
             sb.checked, sb.pairs_valid);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
